// ===== sv/qse_pkg.sv =====
// ----------------------------------------------------------------------------
// qse_pkg: shared constants of the quicksort engine
// Default sizes for the element store and the data word.
// ----------------------------------------------------------------------------
package qse_pkg;

  // Default number of elements that one list may hold.
  localparam int unsigned MaxItemsDefault = 64;

  // Default width of one signed element.
  localparam int unsigned ValueWidthDefault = 32;

endpackage

// ===== sv/qse_ram.sv =====
// ----------------------------------------------------------------------------
// qse_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module qse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/qse_cmp.sv =====
// ----------------------------------------------------------------------------
// qse_cmp: shared signed compare unit
// Tells whether a stored element is less than or equal to the pivot.
// ----------------------------------------------------------------------------
module qse_cmp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] elem_i,
  input  logic [WIDTH-1:0] pivot_i,
  output logic             le_o
);

  assign le_o = ($signed(elem_i) <= $signed(pivot_i));

endmodule

// ===== sv/quicksort_engine_top.sv =====
// ----------------------------------------------------------------------------
// quicksort_engine_top: list sorter by iterative quicksort
// Collects signed elements, sorts them ascending and streams them back out.
// ----------------------------------------------------------------------------
// The block takes one element item per cycle into its element store until an
// item arrives with is_final_i set. Elements beyond MAX_ITEMS are dropped and
// overflow_o is raised on every result of that list. While it sorts and while
// it emits, in_ready_o stays low. The sort is quicksort with the first element
// of each range as pivot; pending index ranges sit on a stack held in a small
// memory. All work runs through one single-port-read element memory and one
// signed compare unit, so the sort time is set by the memory: every scanned
// element costs one store read, every exchange costs two writes and a fresh
// stop of each scan, and every range costs a stack pop, a pivot read, the
// first scan stops and final placement. An already sorted list is the
// slowest case. Each result is read from the store in its own state before it
// is offered, so results do not leave back to back even when out_ready_i is
// held high, with is_final_out_o marking the last one. After the last result
// is taken the block is empty and accepts the next list. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module quicksort_engine_top
  import qse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS   = MaxItemsDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] element_value_i,
  input  logic                          is_final_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                          is_final_out_o,
  output logic                          overflow_o
);

  // Index width into the store and width of a count that can reach MAX_ITEMS.
  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    StLoad,
    StInit,
    StPop,
    StPopWait,
    StPivot,
    StScanLow,
    StScanHigh,
    StSwapA,
    StSwapB,
    StPlaceA,
    StPlaceB,
    StEmitRead,
    StEmitOut
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          sp_q, sp_d;
  logic                   drop_q, drop_d;
  logic [IW-1:0]          lo_q, lo_d;
  logic [IW-1:0]          hi_q, hi_d;
  logic [IW-1:0]          sl_q, sl_d;
  logic [IW-1:0]          sh_q, sh_d;
  logic [IW-1:0]          k_q, k_d;
  logic [VALUE_WIDTH-1:0] pivot_q, pivot_d;
  logic [VALUE_WIDTH-1:0] vl_q, vl_d;
  logic [VALUE_WIDTH-1:0] vh_q, vh_d;

  // Element store ports.
  logic                   st_we;
  logic [IW-1:0]          st_waddr;
  logic [VALUE_WIDTH-1:0] st_wdata;
  logic [IW-1:0]          st_raddr;
  logic [VALUE_WIDTH-1:0] st_rdata;

  // Range stack ports; an entry is {low index, high index}.
  logic                   sk_we;
  logic [IW-1:0]          sk_waddr;
  logic [2*IW-1:0]        sk_wdata;
  logic [IW-1:0]          sk_raddr;
  logic [2*IW-1:0]        sk_rdata;

  logic [IW-1:0]          stk_lo;
  logic [IW-1:0]          stk_hi;
  logic [CW-1:0]          sp_m1;
  logic [CW-1:0]          count_m1;
  logic                   le;
  logic                   last_k;
  logic                   stack_room;

  assign stk_lo     = sk_rdata[2*IW-1:IW];
  assign stk_hi     = sk_rdata[IW-1:0];
  assign sp_m1      = sp_q - CW'(1);
  assign count_m1   = count_q - CW'(1);
  assign last_k     = (CW'(k_q) == count_m1);
  assign stack_room = (sp_q < CW'(MAX_ITEMS));

  qse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  qse_ram #(
    .WIDTH (2 * IW),
    .DEPTH (MAX_ITEMS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  // The one compare unit serves both scans: the low scan advances while the
  // element is at most the pivot, the high scan retreats while it is above.
  qse_cmp #(
    .WIDTH (VALUE_WIDTH)
  ) u_cmp (
    .elem_i  (st_rdata),
    .pivot_i (pivot_q),
    .le_o    (le)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sp_d     = sp_q;
    drop_d   = drop_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    sl_d     = sl_q;
    sh_d     = sh_q;
    k_d      = k_q;
    pivot_d  = pivot_q;
    vl_d     = vl_q;
    vh_d     = vh_q;

    st_we    = 1'b0;
    st_waddr = sl_q;
    st_wdata = vh_q;
    st_raddr = sl_q;
    sk_we    = 1'b0;
    sk_waddr = sp_q[IW-1:0];
    sk_wdata = {lo_q, hi_q};
    sk_raddr = sp_m1[IW-1:0];

    case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          if (count_q < CW'(MAX_ITEMS)) begin
            st_we    = 1'b1;
            st_waddr = count_q[IW-1:0];
            st_wdata = element_value_i;
            count_d  = count_q + CW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (is_final_i) begin
            state_d = StInit;
          end
        end
      end

      StInit: begin
        k_d = '0;
        if (count_q < CW'(2)) begin
          state_d = StEmitRead;
        end else begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {IW'(0), count_m1[IW-1:0]};
          sp_d     = CW'(1);
          state_d  = StPop;
        end
      end

      StPop: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = StEmitRead;
        end else begin
          sp_d    = sp_m1;
          state_d = StPopWait;
        end
      end

      StPopWait: begin
        lo_d     = stk_lo;
        hi_d     = stk_hi;
        st_raddr = stk_lo;
        if ((stk_lo >= stk_hi) || (CW'(stk_hi) >= count_q)) begin
          state_d = StPop;
        end else begin
          state_d = StPivot;
        end
      end

      StPivot: begin
        pivot_d  = st_rdata;
        sl_d     = lo_q;
        sh_d     = hi_q;
        st_raddr = lo_q;
        state_d  = StScanLow;
      end

      StScanLow: begin
        if ((sl_q < hi_q) && le) begin
          sl_d     = sl_q + IW'(1);
          st_raddr = sl_q + IW'(1);
        end else begin
          vl_d     = st_rdata;
          st_raddr = sh_q;
          state_d  = StScanHigh;
        end
      end

      StScanHigh: begin
        if ((sh_q > lo_q) && !le) begin
          sh_d     = sh_q - IW'(1);
          st_raddr = sh_q - IW'(1);
        end else begin
          vh_d = st_rdata;
          if (sl_q < sh_q) begin
            state_d = StSwapA;
          end else begin
            state_d = StPlaceA;
          end
        end
      end

      StSwapA: begin
        st_we    = 1'b1;
        st_waddr = sl_q;
        st_wdata = vh_q;
        state_d  = StSwapB;
      end

      StSwapB: begin
        st_we    = 1'b1;
        st_waddr = sh_q;
        st_wdata = vl_q;
        st_raddr = sl_q;
        state_d  = StScanLow;
      end

      StPlaceA: begin
        // The element at the split goes to the head of the range; the lower
        // subrange is queued if it holds at least two elements and stack has room.
        st_we    = 1'b1;
        st_waddr = lo_q;
        st_wdata = vh_q;
        if (({1'b0, sh_q} > ({1'b0, lo_q} + (IW+1)'(1))) && stack_room) begin
          sk_we    = 1'b1;
          sk_wdata = {lo_q, sh_q - IW'(1)};
          sp_d     = sp_q + CW'(1);
        end
        state_d = StPlaceB;
      end

      StPlaceB: begin
        st_we    = 1'b1;
        st_waddr = sh_q;
        st_wdata = pivot_q;
        if ((({1'b0, sh_q} + (IW+1)'(1)) < {1'b0, hi_q}) && stack_room) begin
          sk_we    = 1'b1;
          sk_wdata = {sh_q + IW'(1), hi_q};
          sp_d     = sp_q + CW'(1);
        end
        state_d = StPop;
      end

      StEmitRead: begin
        st_raddr = k_q;
        state_d  = StEmitOut;
      end

      StEmitOut: begin
        st_raddr = k_q;
        if (out_ready_i) begin
          if (last_k) begin
            count_d = '0;
            sp_d    = '0;
            drop_d  = 1'b0;
            state_d = StLoad;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = StEmitRead;
          end
        end
      end

      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
      sp_q    <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sp_q    <= sp_d;
      drop_q  <= drop_d;
      k_q     <= k_d;
    end
  end

  // Working registers of a partition need no reset.
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    sl_q    <= sl_d;
    sh_q    <= sh_d;
    pivot_q <= pivot_d;
    vl_q    <= vl_d;
    vh_q    <= vh_d;
  end

  // The result comes straight from the registered store read, which holds
  // its address while a result waits.
  assign in_ready_o     = (state_q == StLoad);
  assign out_valid_o    = (state_q == StEmitOut);
  assign sorted_value_o = $signed(st_rdata);
  assign is_final_out_o = last_k;
  assign overflow_o     = drop_q;

endmodule

// ===== sv/qse_checker.sv =====
// ----------------------------------------------------------------------------
// qse_checker: port-level checks for the quicksort engine
// Watches the handshakes of the top level and flags ordering slips.
// ----------------------------------------------------------------------------
module qse_checker
  import qse_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          is_final_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic signed [VALUE_WIDTH-1:0] sorted_value_o,
  input logic                          is_final_out_o,
  input logic                          overflow_o
);

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is offered");

  // The final item of a list closes the input side.
  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && is_final_i) |=> !in_ready_o)
    else $error("input still ready after the final item");

  // A non-final item keeps the block loading.
  a_keep_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !is_final_i) |=> (in_ready_o && !out_valid_o))
    else $error("block left loading before the final item");

  // Once the last result is taken, no further result follows at once.
  a_list_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && is_final_out_o) |=> !out_valid_o)
    else $error("result offered after the last item of a list");

  // A waiting result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sorted_value_o) && $stable(is_final_out_o)
       && $stable(overflow_o)))
    else $error("waiting result changed");

endmodule

bind quicksort_engine_top qse_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_qse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .is_final_i      (is_final_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .sorted_value_o  (sorted_value_o),
  .is_final_out_o  (is_final_out_o),
  .overflow_o      (overflow_o)
);

// ===== test/quicksort_checker.sv =====
// ----------------------------------------------------------------------------
// quicksort_checker: result checker for the quicksort engine
// Watches both channels, builds the expected sorted list for every list that
// is loaded and compares each result item with the oldest expected entry.
// ----------------------------------------------------------------------------
module quicksort_checker #(
  parameter int unsigned MAX_ITEMS   = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] element_value_i,
  input  logic                          is_final_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] sorted_value_i,
  input  logic                          is_final_out_i,
  input  logic                          overflow_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            lists_o,
  output int                            results_o,
  output int                            dropped_lists_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  typedef struct {
    word_t value;
    logic  last;
    logic  dropped;
  } sorted_entry_t;

  word_t         loaded_list[$];
  sorted_entry_t sorted_expect[$];
  logic          dropped_seen  = 1'b0;
  int            error_count   = 0;
  int            pending_count = 0;
  int            list_count    = 0;
  int            result_count  = 0;
  int            dropped_count = 0;

  assign errors_o        = error_count;
  assign pending_o       = pending_count;
  assign lists_o         = list_count;
  assign results_o       = result_count;
  assign dropped_lists_o = dropped_count;

  // Ascending signed order; only the values matter, so any correct sort
  // gives the same sequence as the engine's quicksort.
  function automatic void sort_loaded_list();
    word_t key;
    int    j;
    for (int i = 1; i < loaded_list.size(); i++) begin
      key = loaded_list[i];
      j   = i - 1;
      while (j >= 0 && loaded_list[j] > key) begin
        loaded_list[j + 1] = loaded_list[j];
        j--;
      end
      loaded_list[j + 1] = key;
    end
  endfunction

  function automatic void queue_sorted_list();
    sorted_entry_t entry;
    sort_loaded_list();
    for (int k = 0; k < loaded_list.size(); k++) begin
      entry.value   = loaded_list[k];
      entry.last    = (k == loaded_list.size() - 1);
      entry.dropped = dropped_seen;
      sorted_expect.push_back(entry);
    end
    list_count++;
    if (dropped_seen) dropped_count++;
    loaded_list.delete();
    dropped_seen = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sorted_entry_t head;
    if (!rst_ni) begin
      loaded_list.delete();
      sorted_expect.delete();
      dropped_seen  = 1'b0;
      pending_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_count++;
        if (sorted_expect.size() == 0) begin
          $error("unexpected result item: sorted_value %0d", sorted_value_i);
          error_count++;
        end else begin
          head = sorted_expect.pop_front();
          if (sorted_value_i !== head.value) begin
            $error("sorted_value mismatch: expected %0d, actual %0d",
                   head.value, sorted_value_i);
            error_count++;
          end
          if (is_final_out_i !== head.last) begin
            $error("is_final_out mismatch: expected %0b, actual %0b",
                   head.last, is_final_out_i);
            error_count++;
          end
          if (overflow_i !== head.dropped) begin
            $error("overflow mismatch: expected %0b, actual %0b",
                   head.dropped, overflow_i);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        // Elements past the store capacity are lost; a lost final element
        // still closes the list.
        if (loaded_list.size() < MAX_ITEMS) loaded_list.push_back(element_value_i);
        else dropped_seen = 1'b1;
        if (is_final_i) queue_sorted_list();
      end
      pending_count = sorted_expect.size();
    end
  end

endmodule

// ===== test/tb_quicksort_engine_top.sv =====
// ----------------------------------------------------------------------------
// tb_quicksort_engine_top: testbench of the quicksort engine
// Loads lists of signed elements through the input channel, lets the engine
// sort them and has a checker compare every sorted item with its own sorted
// copy of the list, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_quicksort_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import qse_pkg::*;

  localparam int unsigned MaxItems   = MaxItemsDefault;
  localparam int unsigned ValueWidth = ValueWidthDefault;

  // Least number of random element items to send after the directed lists.
  localparam int RandomItems = 420;

  // A sorted 64-element list is the slowest case, with no handshake at all
  // while it sorts, so the limit sits well above its sort time.
  localparam int WatchdogLimit = 20000;

  // Cycles to wait after the last expected item for stray results.
  localparam int DrainCycles = 40;

  typedef logic signed [ValueWidth-1:0] word_t;

  // How the values of one list are drawn.
  typedef enum int {
    ValFull,
    ValWide,
    ValNarrow,
    ValExtreme
  } value_mode_e;

  // How the values of one list are ordered.
  typedef enum int {
    OrderRandom,
    OrderAscending,
    OrderDescending
  } order_mode_e;

  // Behaviour of the result receiver over one stretch of cycles.
  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyPeriodic
  } ready_mode_e;

  logic  clk_i           = 1'b0;
  logic  rst_ni          = 1'b0;
  logic  in_valid_i      = 1'b0;
  logic  in_ready_o;
  word_t element_value_i = '0;
  logic  is_final_i      = 1'b0;
  logic  out_valid_o;
  logic  out_ready_i     = 1'b0;
  word_t sorted_value_o;
  logic  is_final_out_o;
  logic  overflow_o;

  int errors;
  int pending;
  int lists_done;
  int results_done;
  int dropped_lists;

  // Sender burst bookkeeping: items left in the current burst.
  int burst_left = 0;

  // Receiver stall pattern bookkeeping.
  ready_mode_e ready_mode  = ReadyAlways;
  int          ready_left  = 0;
  int          ready_phase = 0;

  // Cycles since the last accepted item on either channel.
  int idle_cycles = 0;

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quicksort_engine_top #(
    .MAX_ITEMS  (MaxItems),
    .VALUE_WIDTH(ValueWidth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .element_value_i(element_value_i),
    .is_final_i     (is_final_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .is_final_out_o (is_final_out_o),
    .overflow_o     (overflow_o)
  );

  // The checker sits beside the engine and sees exactly what its ports see.
  quicksort_checker #(
    .MAX_ITEMS  (MaxItems),
    .VALUE_WIDTH(ValueWidth)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .element_value_i(element_value_i),
    .is_final_i     (is_final_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_i (sorted_value_o),
    .is_final_out_i (is_final_out_o),
    .overflow_i     (overflow_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .lists_o        (lists_done),
    .results_o      (results_done),
    .dropped_lists_o(dropped_lists)
  );

  // The receiver switches between stall patterns at random, so stalls land on
  // every part of the result stream, including the item that carries the
  // final mark. The always-ready pattern gives stretches with no stalls at all.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (ready_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        ready_left = $urandom_range(32, 256);
      end
      ready_left--;
      ready_phase++;
      case (ready_mode)
        ReadyAlways: begin
          out_ready_i <= 1'b1;
        end
        ReadyCoin: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        ReadySparse: begin
          out_ready_i <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          out_ready_i <= ((ready_phase % 7) < 3);
        end
      endcase
    end
  end

  // Watchdog: the run is declared hung when no item moves on either channel
  // for too long. Long sorts are covered by the size of the limit.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no item accepted for %0d cycles", WatchdogLimit);
        $display("FAIL quicksort_engine_top");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Draws one element value. The narrow mode makes many equal elements,
  // which exercises the rule that ties go to the lower subrange.
  function automatic word_t pick_value(value_mode_e mode);
    word_t value;
    case (mode)
      ValNarrow: begin
        value = $signed($urandom_range(0, 8)) - 4;
      end
      ValExtreme: begin
        case ($urandom_range(0, 4))
          0:       value = {1'b1, {(ValueWidth - 1){1'b0}}};
          1:       value = {1'b0, {(ValueWidth - 1){1'b1}}};
          2:       value = '0;
          3:       value = '1;
          default: value = 1;
        endcase
      end
      default: begin
        value = $urandom;
      end
    endcase
    return value;
  endfunction

  // Sends one element item. The sender works in bursts: when a burst runs
  // out, a new length is drawn and, most of the time, a gap with valid low
  // and junk on the payload comes first. The next item of a burst raises
  // valid at the falling edge right after the previous one was taken, so
  // valid never drops between items of a burst.
  task automatic send_element(input word_t value, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i      <= 1'b0;
        element_value_i <= $urandom;
        is_final_i      <= 1'($urandom_range(0, 1));
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    is_final_i      <= last;
    // Ready is low while the engine sorts and emits, so the wait covers the
    // whole sort of the previous list.
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sends a whole list given as a queue; the last element carries the mark.
  task automatic send_list(input word_t values[$]);
    for (int k = 0; k < values.size(); k++) begin
      send_element(values[k], k == values.size() - 1);
    end
  endtask

  initial begin : stimulus
    word_t       values[$];
    word_t       base;
    int          length;
    int          list_index;
    int          sent;
    int          pick;
    value_mode_e vmode;
    order_mode_e omode;

    // Reset is held low from the start and released at a falling edge.
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lists. A single element: the sort has nothing to do.
    values = '{{1'b0, {(ValueWidth - 1){1'b1}}}};
    send_list(values);
    // The extremes of the signed range mixed with zero and its neighbors.
    values = '{{1'b1, {(ValueWidth - 1){1'b0}}}, {1'b0, {(ValueWidth - 1){1'b1}}},
               word_t'(0), word_t'(-1), word_t'(1)};
    send_list(values);
    // Many elements equal to the pivot.
    values = '{word_t'(5), word_t'(5), word_t'(5), word_t'(-5), word_t'(5)};
    send_list(values);
    // An already sorted list, the slow case of a first-element pivot.
    values = '{word_t'(1), word_t'(2), word_t'(3), word_t'(4)};
    send_list(values);
    // A list in descending order.
    values = '{word_t'(3), word_t'(2), word_t'(1)};
    send_list(values);

    // Random lists. The first overflows the store so that the final element
    // itself is dropped, the second fills it exactly; after that most lists
    // are short, with an occasional long or overflowing one.
    sent       = 0;
    list_index = 0;
    while (sent < RandomItems) begin
      if (list_index == 0) begin
        length = MaxItems + 1 + $urandom_range(0, 3);
      end else if (list_index == 1) begin
        length = MaxItems;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 3) length = $urandom_range(MaxItems - 2, MaxItems + 3);
        else if (pick < 15) length = $urandom_range(13, 40);
        else length = $urandom_range(1, 12);
      end
      vmode = value_mode_e'($urandom_range(0, 3));
      pick  = $urandom_range(0, 5);
      omode = (pick == 4) ? OrderAscending :
              (pick == 5) ? OrderDescending : OrderRandom;
      base  = $signed($urandom_range(0, 2000)) - 1000;
      values.delete();
      for (int k = 0; k < length; k++) begin
        case (omode)
          OrderAscending:  values.push_back(base + k);
          OrderDescending: values.push_back(base - k);
          default:         values.push_back(pick_value(vmode));
        endcase
      end
      send_list(values);
      sent += length;
      list_index++;
    end

    // Stop sending, then wait for every expected item and a short drain in
    // which any stray result would show up as unexpected.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d lists and %0d sorted items, %0d lists with dropped elements.",
             lists_done, results_done, dropped_lists);
    if (errors == 0) begin
      $display("PASS quicksort_engine_top");
    end else begin
      $display("%0d mismatches found", errors);
      $display("FAIL quicksort_engine_top");
    end
    $finish;
  end

endmodule

// ===== quicksort_engine_top.f =====
sv/qse_pkg.sv
sv/qse_ram.sv
sv/qse_cmp.sv
sv/quicksort_engine_top.sv
sv/qse_checker.sv
test/quicksort_checker.sv
test/tb_quicksort_engine_top.sv
